// ===== hdl/twqs_pkg.sv =====
// ----------------------------------------------------------------------------
// twqs_pkg
// Shared types, codes and helpers of the two-queue weighted scheduler.
// ----------------------------------------------------------------------------
package twqs_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int JOB_BITS    = 16;
	localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
	localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

	localparam int LIMIT_BITS  = 4;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd3;

	localparam int CMD_QUEUE_DEPTH = 2;
	localparam int CMD_PTR_BITS    = $clog2(CMD_QUEUE_DEPTH);
	localparam int CMD_COUNT_BITS  = $clog2(CMD_QUEUE_DEPTH + 1);

	localparam logic [1:0] ACT_ENQ_URGENT = 2'd0;
	localparam logic [1:0] ACT_ENQ_NORMAL = 2'd1;
	localparam logic [1:0] ACT_SERVE      = 2'd2;

	localparam logic [1:0] FROM_NONE   = 2'd0;
	localparam logic [1:0] FROM_URGENT = 2'd1;
	localparam logic [1:0] FROM_NORMAL = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		OP_PUSH_URGENT,
		OP_PUSH_NORMAL,
		OP_SERVE,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [JOB_BITS-1:0] job;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Ring index (idx + cnt) mod QUEUE_DEPTH for idx, cnt below QUEUE_DEPTH.
	function automatic logic [IDX_BITS-1:0] ring_add(input logic [IDX_BITS-1:0] idx,
			input logic [COUNT_BITS-1:0] cnt);
		logic [COUNT_BITS:0] sum;
		sum = {{(COUNT_BITS + 1 - IDX_BITS){1'b0}}, idx} + {1'b0, cnt};
		if (sum >= (COUNT_BITS + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (COUNT_BITS + 1)'(QUEUE_DEPTH);
		end
		return sum[IDX_BITS-1:0];
	endfunction

endpackage

// ===== hdl/twqs_req_if.sv =====
// ----------------------------------------------------------------------------
// twqs_req_if
// Request channel: one action with its job identifier per transaction.
// ----------------------------------------------------------------------------
interface twqs_req_if;
	import twqs_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic [JOB_BITS-1:0] job_id;

	modport source (output valid, action, job_id, input ready);
	modport sink   (input valid, action, job_id, output ready);
endinterface

// ===== hdl/twqs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// twqs_rsp_if
// Result channel: one served job, its origin and a status per transaction.
// ----------------------------------------------------------------------------
interface twqs_rsp_if;
	import twqs_pkg::*;

	logic                valid;
	logic                ready;
	logic [JOB_BITS-1:0] served_job;
	logic [1:0]          served_from;
	logic [1:0]          status;

	modport source (output valid, served_job, served_from, status, input ready);
	modport sink   (input valid, served_job, served_from, status, output ready);
endinterface

// ===== hdl/twqs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// twqs_cfg_if
// Configuration write channel for the normals-per-urgent limit.
// ----------------------------------------------------------------------------
interface twqs_cfg_if;
	import twqs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [LIMIT_BITS-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/two_queue_weighted_scheduler.sv =====
// ----------------------------------------------------------------------------
// two_queue_weighted_scheduler
// Weighted scheduler over an urgent and a normal job FIFO.
// ----------------------------------------------------------------------------
// Each request transaction enqueues a job into the urgent or the normal FIFO,
// or serves the next job, and yields exactly one result transaction. Service
// alternates one urgent job with up to the configured number of normal jobs,
// skipping an empty queue. The block sustains one transaction per cycle while
// the result side is ready. An accepted request is written into the command
// queue; the back end executes the command at the head of the command queue
// against the FIFO heads and tails, and registers the result. While a
// result waits, two more requests are taken into the command queue before the
// request side stalls. The FIFOs need no clearing after reset. Write the limit
// only while no requests are in flight.
// ----------------------------------------------------------------------------
module two_queue_weighted_scheduler
	import twqs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	twqs_req_if.sink   req,
	twqs_rsp_if.source rsp,
	twqs_cfg_if.sink   cfg
);

	logic          cq_push;
	logic          cq_pop;
	cmd_t          front_cmd;
	cmd_t          head_cmd;
	queue_status_t cq_status;

	twqs_front u_front (
		.req       (req),
		.cq_status (cq_status),
		.cq_push   (cq_push),
		.cq_cmd    (front_cmd)
	);

	twqs_cmd_queue u_cmd_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cq_push),
		.push_cmd (front_cmd),
		.pop      (cq_pop),
		.head_cmd (head_cmd),
		.status   (cq_status)
	);

	twqs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.rsp       (rsp),
		.cq_cmd    (head_cmd),
		.cq_status (cq_status),
		.cq_pop    (cq_pop)
	);

endmodule

// ===== hdl/twqs_front.sv =====
// ----------------------------------------------------------------------------
// twqs_front
// Accepts request transactions and classifies each into a command.
// ----------------------------------------------------------------------------
module twqs_front
	import twqs_pkg::*;
(
	twqs_req_if.sink     req,
	input  queue_status_t cq_status,
	output logic          cq_push,
	output cmd_t          cq_cmd
);

	always_comb begin
		cq_cmd.job = req.job_id;
		case (req.action)
			ACT_ENQ_URGENT: cq_cmd.op = OP_PUSH_URGENT;
			ACT_ENQ_NORMAL: cq_cmd.op = OP_PUSH_NORMAL;
			ACT_SERVE:      cq_cmd.op = OP_SERVE;
			default:        cq_cmd.op = OP_NOP;
		endcase
	end

	assign req.ready = !cq_status.full;
	assign cq_push   = req.valid && !cq_status.full;

endmodule

// ===== hdl/twqs_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// twqs_cmd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module twqs_cmd_queue
	import twqs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cmd_t          push_cmd,
	input  logic          pop,
	output cmd_t          head_cmd,
	output queue_status_t status
);

	cmd_t                      entry_q [CMD_QUEUE_DEPTH];
	logic [CMD_PTR_BITS-1:0]   wr_ptr_q;
	logic [CMD_PTR_BITS-1:0]   rd_ptr_q;
	logic [CMD_COUNT_BITS-1:0] count_q;

	assign status.full  = (count_q == CMD_COUNT_BITS'(CMD_QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_cmd     = entry_q[rd_ptr_q];

	function automatic logic [CMD_PTR_BITS-1:0] ptr_inc(input logic [CMD_PTR_BITS-1:0] p);
		logic [CMD_PTR_BITS-1:0] r;
		if (p == CMD_PTR_BITS'(CMD_QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.full && !pop |-> !push)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.empty |-> !pop)
		else $error("command queue read while empty");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> !status.empty)
		else $error("command queue lost a command");

endmodule

// ===== hdl/twqs_back.sv =====
// ----------------------------------------------------------------------------
// twqs_back
// Holds the two job FIFOs and the weighted turn state, executes one command
// per cycle while the result side accepts, and registers its result.
// ----------------------------------------------------------------------------
module twqs_back
	import twqs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	twqs_cfg_if.sink      cfg,
	twqs_rsp_if.source    rsp,
	input  cmd_t          cq_cmd,
	input  queue_status_t cq_status,
	output logic          cq_pop
);

	logic [JOB_BITS-1:0]   u_store_q [QUEUE_DEPTH];
	logic [JOB_BITS-1:0]   n_store_q [QUEUE_DEPTH];
	logic [IDX_BITS-1:0]   u_head_q;
	logic [IDX_BITS-1:0]   n_head_q;
	logic [COUNT_BITS-1:0] u_count_q;
	logic [COUNT_BITS-1:0] n_count_q;
	logic                  phase_q;
	logic [LIMIT_BITS-1:0] served_q;
	logic [LIMIT_BITS-1:0] limit_q;

	logic                  out_valid_q;
	logic [JOB_BITS-1:0]   out_job_q;
	logic [1:0]            out_from_q;
	logic [1:0]            out_status_q;

	logic                  u_empty, n_empty, u_full, n_full, urgent_turn;
	logic                  u_push, n_push, u_pop, n_pop;
	logic                  phase_d;
	logic [LIMIT_BITS-1:0] served_d, served_base, served_inc;
	logic [JOB_BITS-1:0]   res_job;
	logic [1:0]            res_from, res_status;

	assign cfg.ready = 1'b1;

	assign cq_pop = !cq_status.empty && (!out_valid_q || rsp.ready);

	assign u_empty     = (u_count_q == '0);
	assign n_empty     = (n_count_q == '0);
	assign u_full      = (u_count_q == COUNT_BITS'(QUEUE_DEPTH));
	assign n_full      = (n_count_q == COUNT_BITS'(QUEUE_DEPTH));
	assign urgent_turn = !phase_q || (served_q >= limit_q);

	always_comb begin
		u_push      = 1'b0;
		n_push      = 1'b0;
		u_pop       = 1'b0;
		n_pop       = 1'b0;
		phase_d     = phase_q;
		served_d    = served_q;
		served_base = urgent_turn ? '0 : served_q;
		served_inc  = served_base + 1'b1;
		res_job     = '0;
		res_from    = FROM_NONE;
		res_status  = ST_OK;
		case (cq_cmd.op)
			OP_PUSH_URGENT: begin
				if (u_full) begin
					res_status = ST_FULL;
				end else begin
					u_push = 1'b1;
				end
			end
			OP_PUSH_NORMAL: begin
				if (n_full) begin
					res_status = ST_FULL;
				end else begin
					n_push = 1'b1;
				end
			end
			OP_SERVE: begin
				if (u_empty && n_empty) begin
					res_status = ST_EMPTY;
				end else if ((urgent_turn && !u_empty) || (!urgent_turn && n_empty)) begin
					u_pop    = 1'b1;
					res_job  = u_store_q[u_head_q];
					res_from = FROM_URGENT;
					phase_d  = 1'b1;
					served_d = '0;
				end else begin
					n_pop    = 1'b1;
					res_job  = n_store_q[n_head_q];
					res_from = FROM_NORMAL;
					if (served_inc >= limit_q) begin
						phase_d  = 1'b0;
						served_d = '0;
					end else begin
						phase_d  = 1'b1;
						served_d = served_inc;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cq_pop && u_push) begin
			u_store_q[ring_add(u_head_q, u_count_q)] <= cq_cmd.job;
		end
		if (cq_pop && n_push) begin
			n_store_q[ring_add(n_head_q, n_count_q)] <= cq_cmd.job;
		end
		if (cq_pop) begin
			out_job_q    <= res_job;
			out_from_q   <= res_from;
			out_status_q <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_head_q    <= '0;
			n_head_q    <= '0;
			u_count_q   <= '0;
			n_count_q   <= '0;
			phase_q     <= 1'b0;
			served_q    <= '0;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.data;
			end
			if (cq_pop) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_d;
				served_q    <= served_d;
				if (u_push) begin
					u_count_q <= u_count_q + 1'b1;
				end
				if (n_push) begin
					n_count_q <= n_count_q + 1'b1;
				end
				if (u_pop) begin
					u_count_q <= u_count_q - 1'b1;
					u_head_q  <= ring_add(u_head_q, COUNT_BITS'(1));
				end
				if (n_pop) begin
					n_count_q <= n_count_q - 1'b1;
					n_head_q  <= ring_add(n_head_q, COUNT_BITS'(1));
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.served_job  = out_job_q;
	assign rsp.served_from = out_from_q;
	assign rsp.status      = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		u_count_q <= COUNT_BITS'(QUEUE_DEPTH) && n_count_q <= COUNT_BITS'(QUEUE_DEPTH))
		else $error("job queue occupancy out of range");

	a_window_in_phase: assert property (@(posedge clk) disable iff (!arst_n)
		served_q != '0 |-> phase_q)
		else $error("normal window count set outside the normal phase");

	a_empty_serve_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop && cq_cmd.op == OP_SERVE && u_empty && n_empty
		|=> $stable(phase_q) && $stable(served_q) && u_count_q == '0 && n_count_q == '0)
		else $error("serve on empty queues changed scheduler state");

	a_served_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_from_q != FROM_NONE |-> out_status_q == ST_OK)
		else $error("served job reported with an error status");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-queue weighted scheduler.
// ----------------------------------------------------------------------------
// A short table of directed requests is followed by phases of random traffic.
// The phases use different limits, mixes of enqueues and serves, and idle
// patterns. Every accepted request is run through an in-bench model of the
// two FIFOs and the weighted turn rule; typed directed rows take the table's
// result instead. Result transactions are compared in order against these.
// One phase stalls the result side for a long stretch while requests keep coming.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import twqs_pkg::*;

	typedef struct packed {
		logic [JOB_BITS-1:0] served_job;
		logic [1:0]          served_from;
		logic [1:0]          status;
	} sched_result_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [JOB_BITS-1:0] job;
		logic                typed;
		sched_result_t       result;
	} stim_row_t;

	typedef struct packed {
		logic [4:0]  limit;
		logic [15:0] items;
		logic [6:0]  push_pct;
		logic        idle;
		logic        pressure;
	} traffic_phase_t;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam int NOISE_PCT    = 4;
	localparam logic [4:0] RANDOM_LIMIT = 5'd16;

	localparam sched_result_t NO_JOB_OK   = '{'0, FROM_NONE, ST_OK};
	localparam sched_result_t BOTH_EMPTY  = '{'0, FROM_NONE, ST_EMPTY};
	localparam sched_result_t FIRST_URGENT = '{16'hFFFF, FROM_URGENT, ST_OK};

	localparam int DIRECTED_ROWS = 25;
	localparam stim_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
		'{ACT_SERVE,      16'h1234, 1'b1, BOTH_EMPTY},
		'{OP_NOP,         16'hFFFF, 1'b1, NO_JOB_OK},
		'{ACT_ENQ_URGENT, 16'hFFFF, 1'b1, NO_JOB_OK},
		'{ACT_ENQ_NORMAL, 16'h0000, 1'b1, NO_JOB_OK},
		'{ACT_ENQ_NORMAL, 16'h8001, 1'b1, NO_JOB_OK},
		'{ACT_ENQ_NORMAL, 16'h7FFE, 1'b1, NO_JOB_OK},
		'{ACT_ENQ_URGENT, 16'h0001, 1'b1, NO_JOB_OK},
		'{ACT_SERVE,      16'hFFFF, 1'b1, FIRST_URGENT},
		'{ACT_SERVE,      16'h0000, 1'b0, NO_JOB_OK},
		'{ACT_SERVE,      16'hFFFF, 1'b0, NO_JOB_OK},
		'{ACT_SERVE,      16'h0000, 1'b0, NO_JOB_OK},
		'{ACT_SERVE,      16'hFFFF, 1'b0, NO_JOB_OK},
		'{ACT_SERVE,      16'h0000, 1'b1, BOTH_EMPTY},
		'{ACT_ENQ_URGENT, 16'h00AA, 1'b1, NO_JOB_OK},
		'{ACT_ENQ_URGENT, 16'h5555, 1'b1, NO_JOB_OK},
		'{ACT_SERVE,      16'h0000, 1'b0, NO_JOB_OK},
		'{ACT_SERVE,      16'h0000, 1'b0, NO_JOB_OK},
		'{ACT_ENQ_NORMAL, 16'hAAAA, 1'b1, NO_JOB_OK},
		'{ACT_SERVE,      16'h0000, 1'b0, NO_JOB_OK},
		'{ACT_ENQ_NORMAL, 16'h0F0F, 1'b1, NO_JOB_OK},
		'{ACT_SERVE,      16'h0000, 1'b0, NO_JOB_OK},
		'{ACT_ENQ_NORMAL, 16'hF0F0, 1'b1, NO_JOB_OK},
		'{ACT_SERVE,      16'h0000, 1'b0, NO_JOB_OK},
		'{ACT_ENQ_NORMAL, 16'h1357, 1'b1, NO_JOB_OK},
		'{ACT_SERVE,      16'h0000, 1'b0, NO_JOB_OK}
	};

	localparam int TRAFFIC_PHASES = 11;
	localparam traffic_phase_t TRAFFIC_TABLE [TRAFFIC_PHASES] = '{
		'{5'd0,         16'd120, 7'd50, 1'b1, 1'b0},
		'{5'd1,         16'd120, 7'd85, 1'b1, 1'b0},
		'{5'd1,         16'd100, 7'd15, 1'b1, 1'b0},
		'{5'd15,        16'd150, 7'd80, 1'b1, 1'b0},
		'{5'd15,        16'd120, 7'd20, 1'b0, 1'b0},
		'{5'd3,         16'd120, 7'd95, 1'b0, 1'b1},
		'{RANDOM_LIMIT, 16'd150, 7'd55, 1'b1, 1'b0},
		'{RANDOM_LIMIT, 16'd150, 7'd50, 1'b0, 1'b0},
		'{5'd2,         16'd100, 7'd60, 1'b1, 1'b0},
		'{RANDOM_LIMIT, 16'd100, 7'd45, 1'b1, 1'b0},
		'{5'd3,         16'd50,  7'd50, 1'b1, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	twqs_req_if req_bus ();
	twqs_rsp_if rsp_bus ();
	twqs_cfg_if cfg_bus ();

	two_queue_weighted_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model state of the scheduler.
	logic [JOB_BITS-1:0]   urgent_jobs [$];
	logic [JOB_BITS-1:0]   normal_jobs [$];
	logic                  normal_phase;
	logic [LIMIT_BITS-1:0] normals_done;
	logic [LIMIT_BITS-1:0] normal_limit;

	sched_result_t expected_results [$];

	logic          req_typed;
	sched_result_t req_typed_result;
	logic          tx_idle_on;
	logic          rx_idle_on;
	logic          hold_request;

	int cycle_count;
	int mismatches;
	int requests_sent;
	int limit_writes;
	int urgent_serves;
	int normal_serves;
	int full_refusals;
	int empty_serves;
	int long_holds;

	function automatic logic [JOB_BITS-1:0] take_urgent();
		normal_phase = 1'b1;
		normals_done = '0;
		return urgent_jobs.pop_front();
	endfunction

	function automatic logic [JOB_BITS-1:0] take_normal();
		logic [JOB_BITS-1:0] job;
		job = normal_jobs.pop_front();
		normals_done = normals_done + 1'b1;
		if (normals_done >= normal_limit) begin
			normal_phase = 1'b0;
			normals_done = '0;
		end
		return job;
	endfunction

	function automatic sched_result_t schedule_step(input logic [1:0] action,
			input logic [JOB_BITS-1:0] job);
		sched_result_t r;
		logic urgent_turn;
		r = NO_JOB_OK;
		case (action)
			ACT_ENQ_URGENT: begin
				if (urgent_jobs.size() >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					urgent_jobs.push_back(job);
				end
			end
			ACT_ENQ_NORMAL: begin
				if (normal_jobs.size() >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					normal_jobs.push_back(job);
				end
			end
			ACT_SERVE: begin
				urgent_turn = !normal_phase || (normals_done >= normal_limit);
				if (urgent_jobs.size() == 0 && normal_jobs.size() == 0) begin
					r.status = ST_EMPTY;
				end else if (urgent_turn && urgent_jobs.size() != 0) begin
					r.served_job  = take_urgent();
					r.served_from = FROM_URGENT;
				end else if (urgent_turn) begin
					// With no urgent job waiting, a normal job opens a new window.
					normal_phase = 1'b1;
					normals_done = '0;
					r.served_job  = take_normal();
					r.served_from = FROM_NORMAL;
				end else if (normal_jobs.size() != 0) begin
					r.served_job  = take_normal();
					r.served_from = FROM_NORMAL;
				end else begin
					r.served_job  = take_urgent();
					r.served_from = FROM_URGENT;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic send_request(input logic [1:0] action, input logic [JOB_BITS-1:0] job,
			input logic typed, input sched_result_t typed_result);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid    <= 1'b1;
		req_bus.action   <= action;
		req_bus.job_id   <= job;
		req_typed        <= typed;
		req_typed_result <= typed_result;
		do @(posedge clk); while (!req_bus.ready);
		requests_sent++;
	endtask

	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	always @(posedge clk) begin : monitor
		sched_result_t predicted;
		sched_result_t got;
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding.", cycle_count,
				expected_results.size());
			$display("== FAIL ==");
			$finish;
		end else if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				normal_limit = cfg_bus.data;
				limit_writes++;
			end
			if (req_bus.valid && req_bus.ready) begin
				predicted = schedule_step(req_bus.action, req_bus.job_id);
				if (req_typed) begin
					predicted = req_typed_result;
				end
				expected_results.push_back(predicted);
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				got = '{rsp_bus.served_job, rsp_bus.served_from, rsp_bus.status};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Unexpected result: job %h from %0d status %0d",
							got.served_job, got.served_from, got.status);
					end
				end else begin
					predicted = expected_results.pop_front();
					if (got !== predicted) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch: expected job %h from %0d status %0d, got job %h from %0d status %0d",
								predicted.served_job, predicted.served_from, predicted.status,
								got.served_job, got.served_from, got.status);
						end
					end
					if (predicted.served_from == FROM_URGENT) urgent_serves++;
					if (predicted.served_from == FROM_NORMAL) normal_serves++;
					if (predicted.status == ST_FULL) full_refusals++;
					if (predicted.status == ST_EMPTY) empty_serves++;
				end
			end
		end
	end

	// Result side: random stalls, plus one long hold when the stimulus asks.
	initial begin : result_sink
		int stall;
		rsp_bus.ready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				rsp_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				long_holds++;
			end
			stall = rx_idle_on ? $urandom_range(0, 7) : 0;
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
		end
	end

	initial begin : stimulus
		logic [LIMIT_BITS-1:0] cfg_value;
		logic [1:0]            action;
		logic [JOB_BITS-1:0]   job;
		int                    urgent_pct;
		int                    pick;
		traffic_phase_t        phase_cfg;

		arst_n           = 1'b0;
		req_bus.valid    = 1'b0;
		req_bus.action   = ACT_ENQ_URGENT;
		req_bus.job_id   = '0;
		cfg_bus.valid    = 1'b0;
		cfg_bus.data     = LIMIT_RESET;
		req_typed        = 1'b0;
		req_typed_result = NO_JOB_OK;
		tx_idle_on       = 1'b1;
		rx_idle_on       = 1'b1;
		hold_request     = 1'b0;
		normal_phase     = 1'b0;
		normals_done     = '0;
		normal_limit     = LIMIT_RESET;
		cycle_count      = 0;
		mismatches       = 0;
		requests_sent    = 0;
		limit_writes     = 0;
		urgent_serves    = 0;
		normal_serves    = 0;
		full_refusals    = 0;
		empty_serves     = 0;
		long_holds       = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_request(DIRECTED_TABLE[i].action, DIRECTED_TABLE[i].job,
				DIRECTED_TABLE[i].typed, DIRECTED_TABLE[i].result);
		end

		for (int p = 0; p < TRAFFIC_PHASES; p++) begin
			phase_cfg = TRAFFIC_TABLE[p];
			wait_drained();
			repeat (4) @(posedge clk);
			cfg_value = (phase_cfg.limit == RANDOM_LIMIT) ? LIMIT_BITS'($urandom_range(0, 15))
				: phase_cfg.limit[LIMIT_BITS-1:0];
			cfg_bus.valid <= 1'b1;
			cfg_bus.data  <= cfg_value;
			do @(posedge clk); while (!cfg_bus.ready);
			cfg_bus.valid <= 1'b0;

			tx_idle_on = phase_cfg.idle;
			rx_idle_on = phase_cfg.idle;
			if (phase_cfg.pressure) begin
				hold_request = 1'b1;
			end
			urgent_pct = $urandom_range(10, 90);
			for (int i = 0; i < phase_cfg.items; i++) begin
				pick = $urandom_range(0, 99);
				job  = JOB_BITS'($urandom());
				if (pick < NOISE_PCT) begin
					action = OP_NOP;
				end else if (pick < phase_cfg.push_pct) begin
					action = ($urandom_range(0, 99) < urgent_pct) ? ACT_ENQ_URGENT
						: ACT_ENQ_NORMAL;
				end else begin
					action = ACT_SERVE;
				end
				send_request(action, job, 1'b0, NO_JOB_OK);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests over %0d limit settings, %0d urgent and %0d normal serves.",
			requests_sent, limit_writes + 1, urgent_serves, normal_serves);
		$display("Saw %0d full refusals, %0d empty serves, %0d long result holds; %0d mismatches.",
			full_refusals, empty_serves, long_holds, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
